>>> src/occupancy_grid_store_assert.svh
// Assertion macros shared by the RTL.
`ifndef OCCUPANCY_GRID_STORE_ASSERT_SVH
`define OCCUPANCY_GRID_STORE_ASSERT_SVH

// expr must hold at every edge out of reset
`define OGS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("ogs: invariant violated");

// ante implies cons in the same cycle
`define OGS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ogs: implication violated");

// ante implies cons in the next cycle
`define OGS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ogs: next-cycle check violated");

`endif

>>> src/ogs_pkg.sv
package ogs_pkg;

    localparam int GRID_WIDTH  = 64;
    localparam int GRID_HEIGHT = 64;
    localparam int CELL_COUNT  = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_W      = $clog2(CELL_COUNT);
    localparam int CELL_W      = 2;
    localparam int SIZE_W      = 5;
    localparam int OFF_W       = SIZE_W;
    localparam int COORD_W     = 10;

    localparam logic [SIZE_W-1:0] STAMP_SIZE_RESET = SIZE_W'(5);

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_STAMP = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [CELL_W-1:0] CELL_UNKNOWN = 2'd0;
    localparam logic [CELL_W-1:0] CELL_INVALID = 2'd3;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_STAMP,
        S_RDATA
    } t_state;

    typedef logic signed [COORD_W-1:0] t_coord;

    function automatic logic cell_inside(input t_coord x, input t_coord y);
        return (x >= 0) && (x < COORD_W'(GRID_WIDTH)) &&
               (y >= 0) && (y < COORD_W'(GRID_HEIGHT));
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input t_coord x, input t_coord y);
        return ADDR_W'($unsigned(y)) * ADDR_W'(GRID_WIDTH) + ADDR_W'($unsigned(x));
    endfunction

endpackage

>>> src/occupancy_grid_store.sv
// Occupancy grid store: a 64 x 64 map of 2-bit cells (0 unknown, 1 clear, 2 occupied).
// Request stream (s_axis): tuser carries the request kind (write, stamp, read), tdata
// carries the signed column, signed row and the cell state. A transfer is taken only
// in the idle state; one request is processed at a time.
// Result stream (m_axis): one transfer per read request carrying the cell state
// (unknown when the coordinates lie off the grid). Writes and stamps give nothing.
// Config channel: i_cfg_data sets the footprint size; half of it, rounded down, is
// the stamp radius h. It is always ready and applies to the next stamp.
// Requests are bounded by the single write port of the cell memory: a cell write is
// done in the idle state on acceptance, a read result passes the memory's read register
// and the output register, and an area stamp writes (2h+1)^2 cells, one cell per cycle.
// After reset all 4096 cells are swept to unknown, one cell per cycle, with
// s_axis_tready low. The footprint size returns to 5.
// The result sits in an output register: while it waits for m_axis_tready the block
// keeps taking requests; a further read stalls only until that register is freed.
`include "occupancy_grid_store_assert.svh"

module occupancy_grid_store import ogs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [SIZE_W-1:0] i_cfg_data,     // [4:0] stamp_size
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [23:0]       s_axis_tdata,   // [7:0] pos_x, [15:8] pos_y, [17:16] cell_value
    input  logic [1:0]        s_axis_tuser,   // [1:0] req_type
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata    // [1:0] read_value
);

    t_state r_state, n_state;

    logic [SIZE_W-1:0]  r_stamp_size;
    logic [ADDR_W-1:0]  r_clr_addr, n_clr_addr;
    t_coord             r_cx, n_cx, r_cy, n_cy;
    logic signed [OFF_W-1:0] r_dx, n_dx, r_dy, n_dy;
    logic [OFF_W-2:0]   r_h, n_h;
    logic [CELL_W-1:0]  r_val, n_val;
    logic               r_rd_inside, n_rd_inside;
    logic               r_out_valid;
    logic [CELL_W-1:0]  r_out_data;

    logic               in_fire;
    logic [1:0]         in_req;
    logic signed [7:0]  in_x8, in_y8;
    t_coord             in_x, in_y;
    logic [CELL_W-1:0]  in_val;
    logic               in_inside;
    t_coord             st_x, st_y;
    logic signed [OFF_W-1:0] h_pos, h_neg;
    logic               st_row_end, st_done;
    logic               out_load;

    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [CELL_W-1:0]  ram_wdata, ram_rdata;

    assign o_cfg_ready   = 1'b1;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_req        = s_axis_tuser;
    assign in_x8         = s_axis_tdata[7:0];
    assign in_y8         = s_axis_tdata[15:8];
    assign in_val        = s_axis_tdata[17:16];
    assign in_x          = COORD_W'(in_x8);
    assign in_y          = COORD_W'(in_y8);
    assign in_inside     = cell_inside(in_x, in_y);

    assign h_pos         = signed'({1'b0, r_h});
    assign h_neg         = -h_pos;
    assign st_x          = r_cx + COORD_W'(r_dx);
    assign st_y          = r_cy + COORD_W'(r_dy);
    assign st_row_end    = (r_dx == h_pos);
    assign st_done       = st_row_end && (r_dy == h_pos);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_data};

    ogs_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == ADDR_W'(CELL_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    if (in_req == REQ_STAMP && in_val != CELL_INVALID) begin
                        n_state = S_STAMP;
                    end else if (in_req == REQ_READ) begin
                        n_state = S_RDATA;
                    end
                end
            end
            S_STAMP: begin
                if (st_done) begin
                    n_state = S_IDLE;
                end
            end
            S_RDATA: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = CELL_UNKNOWN;
        ram_re        = 1'b0;
        ram_raddr     = '0;
        out_load      = 1'b0;
        n_clr_addr    = r_clr_addr;
        n_cx          = r_cx;
        n_cy          = r_cy;
        n_dx          = r_dx;
        n_dy          = r_dy;
        n_h           = r_h;
        n_val         = r_val;
        n_rd_inside   = r_rd_inside;
        unique case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (in_fire) begin
                    unique case (in_req)
                        REQ_WRITE: begin
                            ram_we    = in_inside && (in_val != CELL_INVALID);
                            ram_waddr = cell_addr(in_x, in_y);
                            ram_wdata = in_val;
                        end
                        REQ_STAMP: begin
                            n_cx  = in_x;
                            n_cy  = in_y;
                            n_val = in_val;
                            n_h   = r_stamp_size[SIZE_W-1:1];
                            n_dx  = -signed'({1'b0, r_stamp_size[SIZE_W-1:1]});
                            n_dy  = -signed'({1'b0, r_stamp_size[SIZE_W-1:1]});
                        end
                        REQ_READ: begin
                            ram_re      = in_inside;
                            ram_raddr   = cell_addr(in_x, in_y);
                            n_rd_inside = in_inside;
                        end
                        default: ;
                    endcase
                end
            end
            S_STAMP: begin
                ram_we    = cell_inside(st_x, st_y);
                ram_waddr = cell_addr(st_x, st_y);
                ram_wdata = r_val;
                if (st_row_end) begin
                    n_dx = h_neg;
                    n_dy = r_dy + 1'b1;
                end else begin
                    n_dx = r_dx + 1'b1;
                end
            end
            S_RDATA: begin
                out_load = !r_out_valid || m_axis_tready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_stamp_size <= STAMP_SIZE_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            if (i_cfg_valid && o_cfg_ready) begin
                r_stamp_size <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx        <= n_cx;
        r_cy        <= n_cy;
        r_dx        <= n_dx;
        r_dy        <= n_dy;
        r_h         <= n_h;
        r_val       <= n_val;
        r_rd_inside <= n_rd_inside;
        if (out_load) begin
            r_out_data <= r_rd_inside ? ram_rdata : CELL_UNKNOWN;
        end
    end

    `OGS_ASSERT_IMPLY(a_waddr_range, i_clk, i_rst_n, ram_we, ram_waddr <= ADDR_W'(CELL_COUNT - 1))
    `OGS_ASSERT_IMPLY(a_stamp_offsets, i_clk, i_rst_n, r_state == S_STAMP, (r_dx >= h_neg) && (r_dx <= h_pos) && (r_dy >= h_neg) && (r_dy <= h_pos))
    `OGS_ASSERT_NEXT(a_off_grid_read, i_clk, i_rst_n, out_load && !r_rd_inside, m_axis_tvalid && (m_axis_tdata[1:0] == CELL_UNKNOWN))

endmodule

>>> src/ogs_ram.sv
module ogs_ram #(
    parameter  int WIDTH = 2,
    parameter  int DEPTH = 4096,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
